// File: design/wvac_pkg.sv
// ----------------------------------------------------------------------------
// wvac_pkg
// Widths, types and calibration codes shared by the wind vane classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package wvac_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int SUM_W        = 20;
  localparam int BAND_W       = 10;
  localparam int DIR_W        = 4;
  localparam int SECTOR_COUNT = 16;

  localparam int BLOCK_SAMPLES_DEF = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [BAND_W-1:0]   band_t;
  typedef logic [DIR_W-1:0]    dir_t;

  localparam band_t BAND_RESET = band_t'(40);

  // ladder codes, sector 0 is north, then clockwise
  localparam sample_t SECTOR_CODE [SECTOR_COUNT] = '{
    12'd3541, 12'd2476, 12'd2660, 12'd1123,
    12'd1171, 12'd1029, 12'd1606, 12'd1334,
    12'd2042, 12'd1869, 12'd3159, 12'd3073,
    12'd3881, 12'd3635, 12'd3762, 12'd3341
  };

endpackage

`default_nettype wire

// File: design/wvac_if.sv
// ----------------------------------------------------------------------------
// wvac channel interfaces
// Valid/ready channels for ADC samples and for classified block results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wvac_in_if;
  import wvac_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wvac_out_if;
  import wvac_pkg::*;

  logic    valid;
  logic    ready;
  dir_t    direction;
  logic    no_match;
  sample_t block_average;

  modport source (output valid, output direction, output no_match, output block_average,
                  input ready);
  modport sink   (input valid, input direction, input no_match, input block_average,
                  output ready);
endinterface

`default_nettype wire

// File: design/wind_vane_average_classifier.sv
// ----------------------------------------------------------------------------
// wind_vane_average_classifier
// Block-averages vane ADC samples and decodes the compass sector.
// ----------------------------------------------------------------------------
// one result per BLOCK_SAMPLES requests; total, mean, result registered in turn
// throughput: one sample per cycle; a block's last sample waits on a held total
// stages: block sum register, reciprocal multiply register, window compare register
// reset clears the running sum, sample count, pipeline valids; match band goes to 40
`default_nettype none

module wind_vane_average_classifier #(
  parameter int BLOCK_SAMPLES = wvac_pkg::BLOCK_SAMPLES_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  wvac_in_if.sink          in_chan,
  wvac_out_if.source       out_chan,
  input  wire              cfg_we,
  input  wvac_pkg::band_t  cfg_wdata
);
  import wvac_pkg::*;

  band_t   match_band_r;
  logic    sum_valid;
  logic    sum_ready;
  sum_t    block_sum;
  logic    avg_valid;
  logic    avg_ready;
  sample_t block_avg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_band_r <= BAND_RESET;
    end else if (cfg_we) begin
      match_band_r <= cfg_wdata;
    end
  end

  wvac_accum #(
    .BLOCK_SAMPLES (BLOCK_SAMPLES)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .block_sum (block_sum)
  );

  wvac_divide #(
    .BLOCK_SAMPLES (BLOCK_SAMPLES)
  ) u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .block_sum (block_sum),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .block_avg (block_avg)
  );

  wvac_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .avg_valid  (avg_valid),
    .avg_ready  (avg_ready),
    .block_avg  (block_avg),
    .match_band (match_band_r),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

// File: design/wvac_accum.sv
// ----------------------------------------------------------------------------
// wvac_accum
// Sums incoming samples per block and hands on the block total.
// ----------------------------------------------------------------------------
`default_nettype none

module wvac_accum #(
  parameter int BLOCK_SAMPLES = wvac_pkg::BLOCK_SAMPLES_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  wvac_in_if.sink            in_chan,
  output logic               sum_valid,
  input  wire                sum_ready,
  output wvac_pkg::sum_t     block_sum
);
  import wvac_pkg::*;

  localparam int CNT_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BLOCK_SAMPLES - 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  sum_t             sum_r, sum_nxt;
  sum_t             total_r, total_nxt;
  logic             valid_r, valid_nxt;
  sum_t             sum_add;
  logic             is_last;
  logic             load_ok;
  logic             accept;

  assign is_last = (count_r == LAST_CNT);
  assign load_ok = !valid_r || sum_ready;
  // mid-block samples never wait on the downstream stage
  assign in_chan.ready = !is_last || load_ok;
  assign accept  = in_chan.valid && in_chan.ready;
  assign sum_add = sum_r + sum_t'(in_chan.sample);

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    total_nxt = total_r;
    valid_nxt = valid_r && !sum_ready;
    if (accept) begin
      if (is_last) begin
        count_nxt = '0;
        sum_nxt   = '0;
        total_nxt = sum_add;
        valid_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      valid_r <= valid_nxt;
    end
    total_r <= total_nxt;
  end

  assign sum_valid = valid_r;
  assign block_sum = total_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_CNT)
    else $error("sample count ran past block end");

endmodule

`default_nettype wire

// File: design/wvac_divide.sv
// ----------------------------------------------------------------------------
// wvac_divide
// Block total to truncated mean by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module wvac_divide #(
  parameter int BLOCK_SAMPLES = wvac_pkg::BLOCK_SAMPLES_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                sum_valid,
  output logic               sum_ready,
  input  wvac_pkg::sum_t     block_sum,
  output logic               avg_valid,
  input  wire                avg_ready,
  output wvac_pkg::sample_t  block_avg
);
  import wvac_pkg::*;

  // exact floor division for any total below 2**SUM_W
  localparam int CLOG_N = $clog2(BLOCK_SAMPLES);
  localparam int SHIFT  = SUM_W + CLOG_N;
  localparam int MUL_W  = SUM_W + 2;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + longint'(BLOCK_SAMPLES) - 64'd1) / longint'(BLOCK_SAMPLES);
  localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_FULL);

  logic              valid_r, valid_nxt;
  sample_t           avg_r, avg_nxt;
  logic [PROD_W-1:0] product;
  logic              load;

  assign sum_ready = !valid_r || avg_ready;
  assign load      = sum_valid && sum_ready;
  assign product   = PROD_W'(block_sum) * PROD_W'(RECIP);

  always_comb begin
    valid_nxt = (valid_r && !avg_ready) || load;
    avg_nxt   = avg_r;
    if (load) begin
      avg_nxt = product[SHIFT +: SAMPLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    avg_r <= avg_nxt;
  end

  assign avg_valid = valid_r;
  assign block_avg = avg_r;

  a_floor_div : assert property (@(posedge clk) disable iff (!rst_n)
    load |=> ((32'(avg_r) * BLOCK_SAMPLES <= 32'($past(block_sum))) &&
              (32'($past(block_sum)) < 32'(avg_r) * BLOCK_SAMPLES + BLOCK_SAMPLES)))
    else $error("block mean is not the truncated quotient");

endmodule

`default_nettype wire

// File: design/wvac_classify.sv
// ----------------------------------------------------------------------------
// wvac_classify
// Window compare of the block mean against the sixteen ladder codes.
// ----------------------------------------------------------------------------
`default_nettype none

module wvac_classify (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                avg_valid,
  output logic               avg_ready,
  input  wvac_pkg::sample_t  block_avg,
  input  wvac_pkg::band_t    match_band,
  wvac_out_if.source         out_chan
);
  import wvac_pkg::*;

  localparam int CMP_W = SAMPLE_W + 1;

  logic    valid_r, valid_nxt;
  dir_t    dir_r, dir_nxt;
  logic    miss_r, miss_nxt;
  sample_t avg_r, avg_nxt;
  dir_t    hit_dir;
  logic    hit_miss;
  logic    load;

  assign avg_ready = !valid_r || out_chan.ready;
  assign load      = avg_valid && avg_ready;

  // lowest sector wins where windows overlap, edges included
  always_comb begin
    logic [CMP_W-1:0] avg_w;
    logic [CMP_W-1:0] band_w;
    logic [CMP_W-1:0] code_w;
    avg_w    = CMP_W'(block_avg);
    band_w   = CMP_W'(match_band);
    hit_dir  = '0;
    hit_miss = 1'b1;
    for (int k = SECTOR_COUNT - 1; k >= 0; k--) begin
      code_w = CMP_W'(SECTOR_CODE[k]);
      if ((avg_w + band_w >= code_w) && (avg_w <= code_w + band_w)) begin
        hit_dir  = DIR_W'(k);
        hit_miss = 1'b0;
      end
    end
  end

  always_comb begin
    valid_nxt = (valid_r && !out_chan.ready) || load;
    dir_nxt   = dir_r;
    miss_nxt  = miss_r;
    avg_nxt   = avg_r;
    if (load) begin
      dir_nxt  = hit_dir;
      miss_nxt = hit_miss;
      avg_nxt  = block_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    dir_r  <= dir_nxt;
    miss_r <= miss_nxt;
    avg_r  <= avg_nxt;
  end

  assign out_chan.valid         = valid_r;
  assign out_chan.direction     = dir_r;
  assign out_chan.no_match      = miss_r;
  assign out_chan.block_average = avg_r;

  a_miss_dir_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && miss_r) |-> (dir_r == '0))
    else $error("direction not zero on a miss");

endmodule

`default_nettype wire

// File: bench/wind_vane_result_checker.sv
// ----------------------------------------------------------------------------
// wind_vane_result_checker
// Watches the sample and result channels of the vane classifier, keeps its
// own running block sum and match band, predicts each block's direction and
// average, and compares every delivered result in order.
// ----------------------------------------------------------------------------
module wind_vane_result_checker #(
  parameter int BLOCK_SAMPLES = wvac_pkg::BLOCK_SAMPLES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  wvac_in_if              in_mon,
  wvac_out_if             out_mon,
  input  logic            cfg_we,
  input  wvac_pkg::band_t cfg_wdata,
  output int              pending,
  output int              errors
);
  timeunit 1ns;
  timeprecision 1ps;

  import wvac_pkg::*;

  typedef struct packed {
    dir_t    direction;
    logic    no_match;
    sample_t block_average;
  } vane_result_t;

  vane_result_t predicted_q[$];
  sum_t         block_sum;
  int           samples_in_block;
  band_t        band;

  task automatic flag(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // first window that holds the average wins, edges included
  function automatic vane_result_t classify_block(sum_t total, band_t half_width);
    vane_result_t r;
    int           lo;
    int           hi;
    r.block_average = sample_t'(total / BLOCK_SAMPLES);
    r.direction     = '0;
    r.no_match      = 1'b1;
    for (int k = 0; k < SECTOR_COUNT; k++) begin
      lo = int'(SECTOR_CODE[k]) - int'(half_width);
      hi = int'(SECTOR_CODE[k]) + int'(half_width);
      if (r.no_match && int'(r.block_average) >= lo && int'(r.block_average) <= hi) begin
        r.direction = dir_t'(k);
        r.no_match  = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic check_result();
    vane_result_t want;
    if (predicted_q.size() == 0) begin
      flag($sformatf("result with none outstanding: direction %0d no_match %0b average %0d",
                     out_mon.direction, out_mon.no_match, out_mon.block_average));
    end else begin
      want = predicted_q.pop_front();
      if (out_mon.direction !== want.direction)
        flag($sformatf("direction got %0d expected %0d (average %0d)",
                       out_mon.direction, want.direction, want.block_average));
      if (out_mon.no_match !== want.no_match)
        flag($sformatf("no_match got %0b expected %0b (average %0d)",
                       out_mon.no_match, want.no_match, want.block_average));
      if (out_mon.block_average !== want.block_average)
        flag($sformatf("block_average got %0d expected %0d",
                       out_mon.block_average, want.block_average));
    end
  endtask

  task automatic take_sample(sample_t s);
    block_sum = block_sum + sum_t'(s);
    samples_in_block++;
    if (samples_in_block == BLOCK_SAMPLES) begin
      predicted_q.push_back(classify_block(block_sum, band));
      block_sum        = '0;
      samples_in_block = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      predicted_q.delete();
      block_sum        = '0;
      samples_in_block = 0;
      band             = BAND_RESET;
      errors           = 0;
    end else begin
      if (cfg_we)
        band = cfg_wdata;
      if (out_mon.valid && out_mon.ready)
        check_result();
      if (in_mon.valid && in_mon.ready)
        take_sample(in_mon.sample);
    end
    pending = predicted_q.size();
  end

endmodule

// File: bench/wind_vane_average_classifier_tb.sv
// ----------------------------------------------------------------------------
// wind_vane_average_classifier_tb
// Feeds blocks of vane samples aimed at the calibration windows, their edges
// and the gaps between them, across several match band settings, with random
// gaps on the sample side and random stalls on the result side.
// ----------------------------------------------------------------------------
module wind_vane_average_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wvac_pkg::*;

  localparam int BLOCK = BLOCK_SAMPLES_DEF;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  band_t cfg_wdata;
  int    pending;
  int    errors;
  band_t band_now;
  logic  burst;

  wvac_in_if  in_ch ();
  wvac_out_if out_ch ();

  wind_vane_average_classifier #(.BLOCK_SAMPLES(BLOCK)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  wind_vane_result_checker #(.BLOCK_SAMPLES(BLOCK)) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .errors    (errors)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #20_000_000;
    $display("wind_vane_average_classifier verification failed");
    $finish;
  end

  // mostly short pauses, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) != 0)
      return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic int clamp_code(int v);
    if (v < 0)
      return 0;
    if (v > 4095)
      return 4095;
    return v;
  endfunction

  // result side back-pressure, with calm stretches of no stalling
  initial begin
    int stall_left;
    int calm_left;
    int r;
    stall_left   = 0;
    calm_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left > 0) begin
        calm_left--;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        r = int'($urandom_range(0, 99));
        if (r < 3)
          calm_left = int'($urandom_range(50, 300));
        else if (r < 28)
          stall_left = idle_len();
      end
    end
  end

  // returns right after the posedge at which the request was taken
  task automatic push_sample(sample_t s);
    int g;
    g = 0;
    if (!burst && $urandom_range(0, 99) < 35)
      g = idle_len();
    @(negedge clk);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.sample <= s;
    in_ch.valid  <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // samples scattered around target, last one pulls the sum so that the
  // truncated mean lands on target unless clamping gets in the way
  task automatic send_block(int target, int jitter);
    int total;
    int s;
    target = clamp_code(target);
    total  = 0;
    for (int i = 0; i < BLOCK - 1; i++) begin
      s = clamp_code(target - jitter + int'($urandom_range(0, 2 * jitter)));
      total += s;
      push_sample(sample_t'(s));
    end
    s = clamp_code(BLOCK * target + int'($urandom_range(0, BLOCK - 1)) - total);
    push_sample(sample_t'(s));
  endtask

  task automatic send_noise_block();
    for (int i = 0; i < BLOCK; i++)
      push_sample(sample_t'($urandom_range(0, 4095)));
  endtask

  task automatic send_aimed_block();
    int code;
    int b;
    int target;
    int jitter;
    code = int'(SECTOR_CODE[$urandom_range(0, SECTOR_COUNT - 1)]);
    b    = int'(band_now);
    case ($urandom_range(0, 5))
      0: target = code - b;
      1: target = code + b;
      2: target = code - b - 1;
      3: target = code + b + 1;
      4: target = code;
      default: target = code - b + int'($urandom_range(0, 2 * b));
    endcase
    jitter = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 120));
    send_block(target, jitter);
  endtask

  // band changes only once the pipe has emptied
  task automatic set_band(band_t b);
    stop_input();
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_we   <= 1'b0;
    band_now = b;
  endtask

  initial begin
    int band_plan[7];
    band_plan    = '{0, 1023, 1, -1, 47, -1, 40};
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    band_now     = BAND_RESET;
    burst        = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset band: floor, ceiling, overlap of two windows, edge hit, edge miss
    send_block(0, 0);
    send_block(4095, 0);
    send_block(1147, 0);
    send_block(int'(SECTOR_CODE[12]) + 40, 0);
    send_block(int'(SECTOR_CODE[0]) - 41, 0);

    foreach (band_plan[p]) begin
      if (band_plan[p] < 0)
        set_band(band_t'($urandom_range(2, 1022)));
      else
        set_band(band_t'(band_plan[p]));
      for (int n = 0; n < 10; n++) begin
        burst = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 20)
          send_noise_block();
        else
          send_aimed_block();
      end
      burst = 1'b0;
    end

    stop_input();
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0)
      $display("wind_vane_average_classifier verification clean");
    else
      $display("wind_vane_average_classifier verification failed");
    $finish;
  end

endmodule

// File: sim.f
design/wvac_pkg.sv
design/wvac_if.sv
design/wvac_accum.sv
design/wvac_divide.sv
design/wvac_classify.sv
design/wind_vane_average_classifier.sv
bench/wind_vane_result_checker.sv
bench/wind_vane_average_classifier_tb.sv
